### hw/rtl/c8core_pkg.sv
// ============================================================================
// c8core_pkg
// Shared types and constants for the CHIP-8 instruction core.
// ============================================================================
package c8core_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int MEM_BYTES_DEF   = 4096;
    localparam int SCREEN_ROWS_DEF = 32;

    localparam logic [11:0] FONT_BASE  = 12'h050;
    localparam logic [11:0] START_ADDR = 12'h200;
    localparam int          FONT_BYTES = 80;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_EXEC  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_ROW   = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_MEMRD,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_FETCH_WAIT,
        ST_DECODE,
        ST_CLS,
        ST_BCD,
        ST_STORE,
        ST_LOAD_ADDR,
        ST_LOAD_DATA,
        ST_DRAW_ADDR,
        ST_DRAW_ROW,
        ST_DRAW_XOR,
        ST_FINISH,
        ST_OUT
    } state_t;

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] f;
        case (idx)
            7'd0: f = 8'hF0; 7'd1: f = 8'h90; 7'd2: f = 8'h90; 7'd3: f = 8'h90;
            7'd4: f = 8'hF0; 7'd5: f = 8'h20; 7'd6: f = 8'h60; 7'd7: f = 8'h20;
            7'd8: f = 8'h20; 7'd9: f = 8'h70; 7'd10: f = 8'hF0; 7'd11: f = 8'h10;
            7'd12: f = 8'hF0; 7'd13: f = 8'h80; 7'd14: f = 8'hF0; 7'd15: f = 8'hF0;
            7'd16: f = 8'h10; 7'd17: f = 8'hF0; 7'd18: f = 8'h10; 7'd19: f = 8'hF0;
            7'd20: f = 8'h90; 7'd21: f = 8'h90; 7'd22: f = 8'hF0; 7'd23: f = 8'h10;
            7'd24: f = 8'h10; 7'd25: f = 8'hF0; 7'd26: f = 8'h80; 7'd27: f = 8'hF0;
            7'd28: f = 8'h10; 7'd29: f = 8'hF0; 7'd30: f = 8'hF0; 7'd31: f = 8'h80;
            7'd32: f = 8'hF0; 7'd33: f = 8'h90; 7'd34: f = 8'hF0; 7'd35: f = 8'hF0;
            7'd36: f = 8'h10; 7'd37: f = 8'h20; 7'd38: f = 8'h40; 7'd39: f = 8'h40;
            7'd40: f = 8'hF0; 7'd41: f = 8'h90; 7'd42: f = 8'hF0; 7'd43: f = 8'h90;
            7'd44: f = 8'hF0; 7'd45: f = 8'hF0; 7'd46: f = 8'h90; 7'd47: f = 8'hF0;
            7'd48: f = 8'h10; 7'd49: f = 8'hF0; 7'd50: f = 8'hF0; 7'd51: f = 8'h90;
            7'd52: f = 8'hF0; 7'd53: f = 8'h90; 7'd54: f = 8'h90; 7'd55: f = 8'hE0;
            7'd56: f = 8'h90; 7'd57: f = 8'hE0; 7'd58: f = 8'h90; 7'd59: f = 8'hE0;
            7'd60: f = 8'hF0; 7'd61: f = 8'h80; 7'd62: f = 8'h80; 7'd63: f = 8'h80;
            7'd64: f = 8'hF0; 7'd65: f = 8'hE0; 7'd66: f = 8'h90; 7'd67: f = 8'h90;
            7'd68: f = 8'h90; 7'd69: f = 8'hE0; 7'd70: f = 8'hF0; 7'd71: f = 8'h80;
            7'd72: f = 8'hF0; 7'd73: f = 8'h80; 7'd74: f = 8'hF0; 7'd75: f = 8'hF0;
            7'd76: f = 8'h80; 7'd77: f = 8'hF0; 7'd78: f = 8'h80; 7'd79: f = 8'h80;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

endpackage

### hw/rtl/chip8_instruction_core_top.sv
// ============================================================================
// chip8_instruction_core_top
// CHIP-8 interpreter core: memory, registers, stack, timers and frame store.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry one action each (write byte, execute, read byte,
// read display row); every input beat yields exactly one output beat on
// m_axis. The core handles one beat at a time: s_axis_tready is high only in
// idle, and idle is entered in the same cycle as the result register is loaded.
// A memory write goes straight to the finish step, memory and display row
// reads pass a read step, and instructions pass fetch-high, fetch-low,
// fetch-wait and decode. FX33 adds one step per place-weight subtract plus
// one per digit, FX55 one per register stored, FX65 an address and a data
// step per register, DXYN an address, row read and XOR step per drawn sprite
// row, 00E0 one frame row a cycle; main memory and frame store are single-port.
// After reset the core sweeps all of main memory, loading zeros and the font,
// and clears the frame store; no input beat is taken meanwhile.
// The result beat holds in the output register while m_axis_tready is low; the
// next beat may be taken and run meanwhile, and waits in its finish step.
// ============================================================================
module chip8_instruction_core_top #(
    parameter int STACK_DEPTH = c8core_pkg::STACK_DEPTH_DEF,
    parameter int MEM_BYTES   = c8core_pkg::MEM_BYTES_DEF,
    parameter int SCREEN_ROWS = c8core_pkg::SCREEN_ROWS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[1:0], address[13:2], write_byte[21:14], key_mask[37:22],
    // random_byte[45:38], zero fill[47:46]
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // program_counter[11:0], opcode[27:12], read_byte[35:28], row_bits[99:36],
    // draw_done[100], sound_on[101], fault[102], zero fill[103]
    output logic [103:0] m_axis_tdata
);
    import c8core_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int RW = $clog2(SCREEN_ROWS);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);

    // storage
    logic [7:0]  mem [MEM_BYTES];
    logic [63:0] fb [SCREEN_ROWS];
    logic [11:0] stk [STACK_DEPTH];
    logic [7:0]  v_reg [16];

    state_t state_reg, state_next;
    logic [11:0] pc_reg, pc_next, i_reg, i_next;
    logic [LW-1:0] sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next, st_reg, st_next;
    logic [AW-1:0] cnt_reg, cnt_next;       // init sweep, loop counters
    logic [4:0]  step_reg, step_next;
    logic [15:0] op_reg, op_next;
    logic [1:0]  act_reg, act_next;
    logic [11:0] addr_reg, addr_next;
    logic [7:0]  wb_reg, wb_next;
    logic [15:0] key_reg, key_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [7:0]  tmp_reg, tmp_next;         // sprite line / bcd work
    logic [7:0]  hit_reg, hit_next;
    logic        fault_reg, fault_next, drew_reg, drew_next;
    logic [103:0] out_reg, out_next;
    logic        ov_reg, ov_next;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wd, mem_rd_reg;
    // frame store port
    logic          fb_we;
    logic [RW-1:0] fb_addr;
    logic [63:0]   fb_wd, fb_rd_reg;
    // register file write
    logic          v_we;
    logic [3:0]    v_wa;
    logic [7:0]    v_wd;
    logic          vf_we;
    logic [7:0]    vf_wd;
    logic          stk_we;
    logic [11:0]   stk_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wd;
        end
        mem_rd_reg <= mem[mem_addr];
        if (fb_we)
        begin
            fb[fb_addr] <= fb_wd;
        end
        fb_rd_reg <= fb[fb_addr];
        if (stk_we)
        begin
            stk[sp_reg[SW-1:0]] <= stk_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= 8'd0;
            end
        end
        else
        begin
            if (v_we)
            begin
                v_reg[v_wa] <= v_wd;
            end
            if (vf_we)
            begin
                v_reg[15] <= vf_wd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            pc_reg    <= START_ADDR;
            i_reg     <= START_ADDR;
            sp_reg    <= '0;
            dt_reg    <= '0;
            st_reg    <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            i_reg     <= i_next;
            sp_reg    <= sp_next;
            dt_reg    <= dt_next;
            st_reg    <= st_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        op_reg    <= op_next;
        act_reg   <= act_next;
        addr_reg  <= addr_next;
        wb_reg    <= wb_next;
        key_reg   <= key_next;
        rnd_reg   <= rnd_next;
        tmp_reg   <= tmp_next;
        hit_reg   <= hit_next;
        fault_reg <= fault_next;
        drew_reg  <= drew_next;
        out_reg   <= out_next;
    end

    // decode fields
    logic [3:0]  fx, fy, fn;
    logic [7:0]  nn, vx, vy, v0;
    logic [8:0]  sum9;
    logic [5:0]  x0;
    logic [RW-1:0] y0;
    logic [RW:0] yrow;
    logic [6:0]  font_idx;
    logic [11:0] i_plus;
    logic [63:0] spr;
    logic [70:0] spr_wide;

    assign fx = op_reg[11:8];
    assign fy = op_reg[7:4];
    assign fn = op_reg[3:0];
    assign nn = op_reg[7:0];
    assign vx = v_reg[fx];
    assign vy = v_reg[fy];
    assign v0 = v_reg[0];
    assign x0 = vx[5:0];
    assign y0 = vy[RW-1:0];
    assign yrow = {1'b0, y0} + (RW + 1)'(step_reg);
    assign i_plus = i_reg + {7'd0, step_reg};
    // sprite line positioned at column x0, pixels past column 63 dropped
    assign spr_wide = {tmp_reg, 63'd0} >> x0;
    assign spr = spr_wide[70:7];

    always_comb
    begin
        state_next = state_reg;
        pc_next = pc_reg;
        i_next = i_reg;
        sp_next = sp_reg;
        dt_next = dt_reg;
        st_next = st_reg;
        cnt_next = cnt_reg;
        ov_next = ov_reg;
        step_next = step_reg;
        op_next = op_reg;
        act_next = act_reg;
        addr_next = addr_reg;
        wb_next = wb_reg;
        key_next = key_reg;
        rnd_next = rnd_reg;
        tmp_next = tmp_reg;
        hit_next = hit_reg;
        fault_next = fault_reg;
        drew_next = drew_reg;
        out_next = out_reg;
        mem_we = 1'b0;
        mem_addr = addr_reg[AW-1:0];
        mem_wd = wb_reg;
        fb_we = 1'b0;
        fb_addr = addr_reg[RW-1:0];
        fb_wd = '0;
        v_we = 1'b0;
        v_wa = fx;
        v_wd = 8'd0;
        vf_we = 1'b0;
        vf_wd = 8'd0;
        stk_we = 1'b0;
        stk_wd = pc_reg;
        sum9 = 9'd0;
        font_idx = 7'd0;
        s_axis_tready = 1'b0;

        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                // load font, zero the rest, clear frame rows
                mem_we = 1'b1;
                mem_addr = cnt_reg;
                font_idx = 7'(cnt_reg - AW'(FONT_BASE));
                mem_wd = (cnt_reg >= AW'(FONT_BASE)
                          && cnt_reg < AW'(FONT_BASE + FONT_BYTES))
                         ? font_byte(font_idx) : 8'd0;
                if (cnt_reg < AW'(SCREEN_ROWS))
                begin
                    fb_we = 1'b1;
                    fb_addr = cnt_reg[RW-1:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(MEM_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    act_next = s_axis_tdata[1:0];
                    addr_next = s_axis_tdata[13:2];
                    wb_next = s_axis_tdata[21:14];
                    key_next = s_axis_tdata[37:22];
                    rnd_next = s_axis_tdata[45:38];
                    op_next = 16'd0;
                    fault_next = 1'b0;
                    drew_next = 1'b0;
                    hit_next = 8'd0;
                    tmp_next = 8'd0;
                    step_next = 5'd0;
                    unique case (action_t'(s_axis_tdata[1:0]))
                        ACT_WRITE: state_next = ST_FINISH;
                        ACT_READ:  state_next = ST_MEMRD;
                        ACT_ROW:   state_next = ST_MEMRD;
                        ACT_EXEC:  state_next = ST_FETCH_HI;
                        default:   state_next = ST_FINISH;
                    endcase
                end
            end
            ST_MEMRD:
            begin
                // read presented at addr_reg this cycle, data next
                state_next = ST_FINISH;
            end
            ST_FETCH_HI:
            begin
                mem_addr = pc_reg[AW-1:0];
                state_next = ST_FETCH_LO;
            end
            ST_FETCH_LO:
            begin
                mem_addr = AW'(pc_reg + 12'd1);
                op_next[15:8] = mem_rd_reg;
                state_next = ST_FETCH_WAIT;
            end
            ST_FETCH_WAIT:
            begin
                op_next[7:0] = mem_rd_reg;
                pc_next = pc_reg + 12'd2;
                state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                state_next = ST_FINISH;
                case (op_reg[15:12])
                    4'h0:
                    begin
                        if (op_reg == 16'h00E0)
                        begin
                            drew_next = 1'b1;
                            cnt_next = '0;
                            state_next = ST_CLS;
                        end
                        else if (op_reg == 16'h00EE)
                        begin
                            if (sp_reg == '0)
                            begin
                                fault_next = 1'b1;
                            end
                            else
                            begin
                                sp_next = sp_reg - 1'b1;
                                pc_next = stk[SW'(sp_reg - 1'b1)];
                            end
                        end
                    end
                    4'h1: pc_next = op_reg[11:0];
                    4'h2:
                    begin
                        if (sp_reg >= LW'(STACK_DEPTH))
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            stk_we = 1'b1;
                            sp_next = sp_reg + 1'b1;
                            pc_next = op_reg[11:0];
                        end
                    end
                    4'h3: if (vx == nn) pc_next = pc_reg + 12'd2;
                    4'h4: if (vx != nn) pc_next = pc_reg + 12'd2;
                    4'h5: if (vx == vy) pc_next = pc_reg + 12'd2;
                    4'h6: begin v_we = 1'b1; v_wd = nn; end
                    4'h7: begin v_we = 1'b1; v_wd = vx + nn; end
                    4'h8:
                    begin
                        case (fn)
                            4'h0: begin v_we = 1'b1; v_wd = vy; end
                            4'h1: begin v_we = 1'b1; v_wd = vx | vy; end
                            4'h2: begin v_we = 1'b1; v_wd = vx & vy; end
                            4'h3: begin v_we = 1'b1; v_wd = vx ^ vy; end
                            4'h4:
                            begin
                                sum9 = {1'b0, vx} + {1'b0, vy};
                                v_we = 1'b1; v_wd = sum9[7:0];
                                vf_we = 1'b1; vf_wd = {7'd0, sum9[8]};
                            end
                            4'h5:
                            begin
                                v_we = 1'b1; v_wd = vx - vy;
                                vf_we = 1'b1; vf_wd = {7'd0, vx >= vy};
                            end
                            4'h6:
                            begin
                                v_we = 1'b1; v_wd = {1'b0, vx[7:1]};
                                vf_we = 1'b1; vf_wd = {7'd0, vx[0]};
                            end
                            4'h7:
                            begin
                                v_we = 1'b1; v_wd = vy - vx;
                                vf_we = 1'b1; vf_wd = {7'd0, vy >= vx};
                            end
                            4'hE:
                            begin
                                v_we = 1'b1; v_wd = {vx[6:0], 1'b0};
                                vf_we = 1'b1; vf_wd = {7'd0, vx[7]};
                            end
                            default: ;
                        endcase
                    end
                    4'h9: if (vx != vy) pc_next = pc_reg + 12'd2;
                    4'hA: i_next = op_reg[11:0];
                    4'hB: pc_next = op_reg[11:0] + {4'd0, v0};
                    4'hC: begin v_we = 1'b1; v_wd = rnd_reg & nn; end
                    4'hD:
                    begin
                        drew_next = 1'b1;
                        step_next = 5'd0;
                        state_next = ST_DRAW_ADDR;
                    end
                    4'hE:
                    begin
                        if (nn == 8'h9E && key_reg[vx[3:0]])
                        begin
                            pc_next = pc_reg + 12'd2;
                        end
                        else if (nn == 8'hA1 && !key_reg[vx[3:0]])
                        begin
                            pc_next = pc_reg + 12'd2;
                        end
                    end
                    default:
                    begin
                        case (nn)
                            8'h07: begin v_we = 1'b1; v_wd = dt_reg; end
                            8'h15: dt_next = vx;
                            8'h18: st_next = vx;
                            8'h1E: i_next = i_reg + {4'd0, vx};
                            8'h29: i_next = FONT_BASE + 12'({vx[3:0], 2'b00})
                                            + {8'd0, vx[3:0]};
                            8'h33:
                            begin
                                tmp_next = vx;
                                hit_next = 8'd0;
                                step_next = 5'd0;
                                state_next = ST_BCD;
                            end
                            8'h55:
                            begin
                                step_next = 5'd0;
                                state_next = ST_STORE;
                            end
                            8'h65:
                            begin
                                step_next = 5'd0;
                                state_next = ST_LOAD_ADDR;
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
            ST_CLS:
            begin
                fb_we = 1'b1;
                fb_addr = cnt_reg[RW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(SCREEN_ROWS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_BCD:
            begin
                // one digit per step by repeated subtract of the place weight
                mem_addr = AW'(i_reg + {10'd0, step_reg[1:0]});
                if (step_reg == 5'd0 && tmp_reg >= 8'd100)
                begin
                    tmp_next = tmp_reg - 8'd100;
                    hit_next = hit_reg + 8'd1;
                end
                else if (step_reg == 5'd1 && tmp_reg >= 8'd10)
                begin
                    tmp_next = tmp_reg - 8'd10;
                    hit_next = hit_reg + 8'd1;
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_wd = (step_reg == 5'd2) ? tmp_reg : hit_reg;
                    hit_next = 8'd0;
                    step_next = step_reg + 5'd1;
                    if (step_reg == 5'd2)
                    begin
                        hit_next = 8'd0;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_STORE:
            begin
                mem_we = 1'b1;
                mem_addr = AW'(i_plus);
                mem_wd = v_reg[step_reg[3:0]];
                step_next = step_reg + 5'd1;
                if (step_reg[3:0] == fx)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_LOAD_ADDR:
            begin
                mem_addr = AW'(i_plus);
                state_next = ST_LOAD_DATA;
            end
            ST_LOAD_DATA:
            begin
                v_we = 1'b1;
                v_wa = step_reg[3:0];
                v_wd = mem_rd_reg;
                step_next = step_reg + 5'd1;
                state_next = (step_reg[3:0] == fx) ? ST_FINISH : ST_LOAD_ADDR;
            end
            ST_DRAW_ADDR:
            begin
                if (step_reg == {1'b0, fn} || yrow >= (RW + 1)'(SCREEN_ROWS))
                begin
                    vf_we = 1'b1;
                    vf_wd = {7'd0, hit_reg[0]};
                    state_next = ST_FINISH;
                end
                else
                begin
                    mem_addr = AW'(i_plus);
                    state_next = ST_DRAW_ROW;
                end
            end
            ST_DRAW_ROW:
            begin
                tmp_next = mem_rd_reg;
                fb_addr = yrow[RW-1:0];
                state_next = ST_DRAW_XOR;
            end
            ST_DRAW_XOR:
            begin
                fb_addr = yrow[RW-1:0];
                fb_we = 1'b1;
                fb_wd = fb_rd_reg ^ spr;
                if ((fb_rd_reg & spr) != 64'd0)
                begin
                    hit_next = 8'd1;
                end
                step_next = step_reg + 5'd1;
                state_next = ST_DRAW_ADDR;
            end
            ST_FINISH:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    if (act_reg == ACT_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    if (act_reg == ACT_EXEC)
                    begin
                        dt_next = (dt_reg != 8'd0) ? dt_reg - 8'd1 : dt_reg;
                        st_next = (st_reg != 8'd0) ? st_reg - 8'd1 : st_reg;
                    end
                    out_next[11:0] = pc_reg;
                    out_next[27:12] = op_reg;
                    out_next[35:28] = (act_reg == ACT_READ) ? mem_rd_reg : 8'd0;
                    out_next[99:36] = (act_reg == ACT_ROW) ? fb_rd_reg : 64'd0;
                    out_next[100] = drew_reg;
                    out_next[101] = (act_reg == ACT_EXEC)
                                    ? (st_reg > 8'd1) : (st_reg != 8'd0);
                    out_next[102] = fault_reg;
                    out_next[103] = 1'b0;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

    // input beats are taken only in idle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (state_reg == ST_IDLE))
        else $error("input beat accepted outside idle");

    // stack level never exceeds the depth
    a_sp: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= LW'(STACK_DEPTH))
        else $error("stack level out of range");

    // a result appears only from the finish step
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result without finish");

endmodule

### bench/chip8_instruction_core_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// chip8_instruction_core_top_tb
// Self-checking bench for the CHIP-8 instruction core: a directed table of
// memory, display and instruction beats, directed instructions, then random
// programs written to memory and executed, all checked against an in-bench model.
// ============================================================================
module chip8_instruction_core_top_tb;
    import c8core_pkg::*;

    // first member in the highest bits, matching the result beat layout
    typedef struct packed {
        logic        flt;
        logic        snd;
        logic        drew;
        logic [63:0] row;
        logic [7:0]  rdb;
        logic [15:0] op;
        logic [11:0] pc;
    } core_result_t;

    typedef struct {
        action_t     act;
        logic [11:0] addr;
        logic [7:0]  wb;
        logic [15:0] keys;
        logic [7:0]  rnd;
        logic        has_exp;
        logic [11:0] exp_pc;
        logic [7:0]  exp_rdb;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    chip8_instruction_core_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // model state
    logic [7:0]  mem [4096];
    logic [7:0]  vreg [16];
    logic [11:0] ireg;
    logic [11:0] pcreg;
    logic [11:0] stk [16];
    int          sp;
    logic [7:0]  dly;
    logic [7:0]  sndc;
    logic [63:0] fb [32];

    core_result_t pending_results [$];
    int           err_cnt;
    bit           quiet;
    int           stall_cnt = 0;

    function automatic void model_reset();
        for (int a = 0; a < 4096; a++)
            mem[a] = 8'h00;
        for (int a = 0; a < FONT_BYTES; a++)
            mem[FONT_BASE + a] = font_byte(7'(a));
        for (int r = 0; r < 16; r++)
            vreg[r] = 8'h00;
        for (int r = 0; r < 32; r++)
            fb[r] = '0;
        ireg  = START_ADDR;
        pcreg = START_ADDR;
        sp    = 0;
        dly   = 0;
        sndc  = 0;
    endfunction

    function automatic logic sprite_draw(int x0, int y0, int n);
        logic hit;
        logic [7:0] ln;
        hit = 1'b0;
        for (int j = 0; j < n; j++)
        begin
            if (y0 + j >= 32)
                break;
            ln = mem[12'(ireg + j)];
            for (int i = 0; i < 8; i++)
            begin
                if (x0 + i >= 64)
                    break;
                if (ln[7 - i])
                begin
                    if (fb[y0 + j][63 - (x0 + i)])
                        hit = 1'b1;
                    fb[y0 + j][63 - (x0 + i)] ^= 1'b1;
                end
            end
        end
        return hit;
    endfunction

    function automatic void exec_op(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd,
                                    inout core_result_t r);
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy;
        logic [11:0] nnn;
        logic [8:0]  sum;
        x = op[11:8]; y = op[7:4]; n = op[3:0];
        nn = op[7:0]; nnn = op[11:0];
        vx = vreg[x]; vy = vreg[y];
        case (op[15:12])
            4'h0:
                if (op == 16'h00E0)
                begin
                    for (int rr = 0; rr < 32; rr++)
                        fb[rr] = '0;
                    r.drew = 1'b1;
                end
                else if (op == 16'h00EE)
                begin
                    if (sp == 0)
                        r.flt = 1'b1;
                    else
                    begin
                        sp--;
                        pcreg = stk[sp];
                    end
                end
            4'h1: pcreg = nnn;
            4'h2:
                if (sp >= 16)
                    r.flt = 1'b1;
                else
                begin
                    stk[sp] = pcreg;
                    sp++;
                    pcreg = nnn;
                end
            4'h3: if (vx == nn) pcreg += 12'd2;
            4'h4: if (vx != nn) pcreg += 12'd2;
            4'h5: if (vx == vy) pcreg += 12'd2;
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] = vx + nn;
            4'h8:
                case (n)
                    4'h0: vreg[x] = vy;
                    4'h1: vreg[x] = vx | vy;
                    4'h2: vreg[x] = vx & vy;
                    4'h3: vreg[x] = vx ^ vy;
                    4'h4:
                    begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        vreg[x] = sum[7:0];
                        vreg[15] = {7'd0, sum[8]};
                    end
                    4'h5:
                    begin
                        vreg[x] = vx - vy;
                        vreg[15] = {7'd0, vx >= vy};
                    end
                    4'h6:
                    begin
                        vreg[x] = vx >> 1;
                        vreg[15] = {7'd0, vx[0]};
                    end
                    4'h7:
                    begin
                        vreg[x] = vy - vx;
                        vreg[15] = {7'd0, vy >= vx};
                    end
                    4'hE:
                    begin
                        vreg[x] = vx << 1;
                        vreg[15] = {7'd0, vx[7]};
                    end
                    default: ;
                endcase
            4'h9: if (vx != vy) pcreg += 12'd2;
            4'hA: ireg = nnn;
            4'hB: pcreg = nnn + vreg[0];
            4'hC: vreg[x] = rnd & nn;
            4'hD:
            begin
                vreg[15] = {7'd0, sprite_draw(vx % 64, vy % 32, n)};
                r.drew = 1'b1;
            end
            4'hE:
                if (nn == 8'h9E && keys[vx[3:0]])
                    pcreg += 12'd2;
                else if (nn == 8'hA1 && !keys[vx[3:0]])
                    pcreg += 12'd2;
            default:
                case (nn)
                    8'h07: vreg[x] = dly;
                    8'h15: dly = vx;
                    8'h18: sndc = vx;
                    8'h1E: ireg = ireg + vx;
                    8'h29: ireg = FONT_BASE + vx[3:0] * 5;
                    8'h33:
                    begin
                        mem[ireg] = vx / 100;
                        mem[12'(ireg + 1)] = (vx / 10) % 10;
                        mem[12'(ireg + 2)] = vx % 10;
                    end
                    8'h55:
                        for (int k = 0; k <= x; k++)
                            mem[12'(ireg + k)] = vreg[k];
                    8'h65:
                        for (int k = 0; k <= x; k++)
                            vreg[k] = mem[12'(ireg + k)];
                    default: ;
                endcase
        endcase
    endfunction

    function automatic core_result_t predict_beat(action_t act, logic [11:0] addr,
                                                  logic [7:0] wb, logic [15:0] keys,
                                                  logic [7:0] rnd);
        core_result_t r;
        r = '0;
        case (act)
            ACT_WRITE: mem[addr] = wb;
            ACT_EXEC:
            begin
                r.op = {mem[pcreg], mem[12'(pcreg + 1)]};
                pcreg += 12'd2;
                exec_op(r.op, keys, rnd, r);
                if (dly != 0) dly--;
                if (sndc != 0) sndc--;
            end
            ACT_READ: r.rdb = mem[addr];
            default: r.row = fb[addr[4:0]];
        endcase
        r.pc  = pcreg;
        r.snd = (sndc != 0);
        return r;
    endfunction

    // tvalid stays high after a beat until the next beat or an explicit drop
    task automatic send_beat(action_t act, logic [11:0] addr, logic [7:0] wb,
                             logic [15:0] keys, logic [7:0] rnd);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, rnd, keys, wb, addr, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results = {pending_results, predict_beat(act, addr, wb, keys, rnd)};
    endtask

    task automatic write_byte(logic [11:0] a, logic [7:0] b);
        send_beat(ACT_WRITE, a, b, 16'h0, 8'h0);
    endtask

    task automatic exec_one();
        send_beat(ACT_EXEC, 12'h0, 8'h0, 16'($urandom), 8'($urandom));
    endtask

    // drop tvalid and hold until every expected result has come
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        core_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[102:0];
            if (m_axis_tdata[103] !== 1'b0 || pending_results.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected or malformed beat %h", m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                    begin
                        $display("mismatch: exp pc=%h op=%h rb=%h row=%h d=%b s=%b f=%b",
                                 want.pc, want.op, want.rdb, want.row, want.drew,
                                 want.snd, want.flt);
                        $display("          got pc=%h op=%h rb=%h row=%h d=%b s=%b f=%b",
                                 got.pc, got.op, got.rdb, got.row, got.drew,
                                 got.snd, got.flt);
                    end
                end
            end
        end
    end

    // output stalls are inserted at random
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || quiet)
        begin
            m_axis_tready <= 1'b1;
            stall_cnt = 0;
        end
        else if (stall_cnt != 0)
        begin
            stall_cnt--;
            m_axis_tready <= (stall_cnt == 0);
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_cnt = $urandom_range(1, 4);
            m_axis_tready <= 1'b0;
        end
    end

    initial
    begin
        #20ms;
        $display("chip8_instruction_core_top_tb: errors");
        $finish;
    end

    stim_row_t dir_rows [$];

    function automatic stim_row_t mk(action_t a, logic [11:0] ad, logic [7:0] wb,
                                     logic [15:0] k, logic [7:0] rn, logic he,
                                     logic [11:0] epc, logic [7:0] erb);
        stim_row_t s;
        s.act = a; s.addr = ad; s.wb = wb; s.keys = k; s.rnd = rn;
        s.has_exp = he; s.exp_pc = epc; s.exp_rdb = erb;
        return s;
    endfunction

    function automatic void table_add(stim_row_t s);
        dir_rows = {dir_rows, s};
    endfunction

    // write one instruction at the current PC and run it
    task automatic run_op(logic [15:0] op);
        write_byte(pcreg, op[15:8]);
        write_byte(12'(pcreg + 1), op[7:0]);
        exec_one();
    endtask

    function automatic logic [15:0] rand_op();
        logic [15:0] op;
        int k;
        op = 16'($urandom);
        k = $urandom_range(0, 19);
        case (k)
            0: op = 16'h00E0;
            1: op = 16'h00EE;
            2, 3: op[15:12] = 4'h8;
            4: op = {4'hF, op[11:8], 8'h33};
            5: op = {4'hF, op[11:8], 8'h55};
            6: op = {4'hF, op[11:8], 8'h65};
            7: op = {4'hF, op[11:8], 8'h15};
            8: op = {4'hF, op[11:8], 8'h18};
            9: op = {4'hF, op[11:8], 8'h29};
            10: op = {4'hF, op[11:8], 8'h07};
            11: op = {4'hE, op[11:8], ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
            12: op = {4'hF, op[11:8], 8'h1E};
            default: ;
        endcase
        // turn other 0NNN opcodes into a return while the stack is empty
        if (op[15:12] == 4'h0 && op != 16'h00E0 && op != 16'h00EE && sp == 0)
            op = 16'h00EE;
        return op;
    endfunction

    initial
    begin
        stim_row_t s;
        logic [15:0] op;
        err_cnt       = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        model_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset state, address extremes, font, empty-stack return
        table_add(mk(ACT_READ,  12'h050, 8'h00, 16'h0, 8'h0, 1'b1, 12'h200, 8'hF0));
        table_add(mk(ACT_READ,  12'h09F, 8'h00, 16'h0, 8'h0, 1'b1, 12'h200, 8'h80));
        table_add(mk(ACT_WRITE, 12'hFFF, 8'hFF, 16'h0, 8'h0, 1'b1, 12'h200, 8'h00));
        table_add(mk(ACT_READ,  12'hFFF, 8'h00, 16'h0, 8'h0, 1'b1, 12'h200, 8'hFF));
        table_add(mk(ACT_ROW,   12'hFFF, 8'h00, 16'hFFFF, 8'hFF, 1'b1, 12'h200, 8'h00));
        table_add(mk(ACT_WRITE, 12'h200, 8'h00, 16'h0, 8'h0, 1'b1, 12'h200, 8'h00));
        table_add(mk(ACT_WRITE, 12'h201, 8'hEE, 16'h0, 8'h0, 1'b1, 12'h200, 8'h00));
        table_add(mk(ACT_EXEC,  12'h000, 8'h00, 16'h0, 8'h0, 1'b1, 12'h202, 8'h00));
        foreach (dir_rows[i])
        begin
            s = dir_rows[i];
            if (s.has_exp)
            begin
                core_result_t r;
                r = predict_beat(s.act, s.addr, s.wb, s.keys, s.rnd);
                if (r.pc !== s.exp_pc || r.rdb !== s.exp_rdb)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("table row %0d: expected pc=%h rb=%h", i, s.exp_pc,
                                 s.exp_rdb);
                end
            end
        end
        // the table check above ran the model; restart it and drive the rows
        model_reset();
        foreach (dir_rows[i])
            send_beat(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].wb,
                      dir_rows[i].keys, dir_rows[i].rnd);

        // a directed run of loads, ALU ops, draws, calls and stores, flag corners and edge draws
        run_op(16'h60FF); run_op(16'h6101); run_op(16'h8014);
        run_op(16'h6205); run_op(16'h6305); run_op(16'h8235); run_op(16'h8237);
        run_op(16'h8016); run_op(16'h801E); run_op(16'h6A3F); run_op(16'h6B1F);
        run_op(16'hF029); run_op(16'hDAB5); run_op(16'hDAB5); run_op(16'h00E0);
        run_op(16'h2300); run_op(16'h00EE); run_op(16'hF0FF); run_op(16'hF118);
        run_op(16'hFF55); run_op(16'hF033); run_op(16'hFF65); run_op(16'hC0FF);

        // random programs
        for (int n = 0; n < 340; n++)
        begin
            if (n == 170)
                drain();
            if (n >= 300)
                quiet = 1'b1;
            case ($urandom_range(0, 9))
                0: send_beat(ACT_WRITE, 12'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom));
                1: send_beat(ACT_READ, 12'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom));
                2: send_beat(ACT_ROW, 12'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom));
                default:
                begin
                    op = rand_op();
                    if (op == 16'h00EE && sp == 0 && $urandom_range(0, 3) != 0)
                        op = 16'h2000 | 16'($urandom_range(0, 4095));
                    // keep jumps near the program area most of the time
                    if (op[15:12] inside {4'h1, 4'h2, 4'hB} && $urandom_range(0, 3) != 0)
                        op[11:8] = 4'h2;
                    run_op(op);
                end
            endcase
        end

        drain();
        repeat (100) @(posedge clk);
        if (err_cnt == 0)
            $display("chip8_instruction_core_top_tb: clean");
        else
            $display("chip8_instruction_core_top_tb: errors");
        $finish;
    end

endmodule

### sim.f
hw/rtl/c8core_pkg.sv
hw/rtl/chip8_instruction_core_top.sv
bench/chip8_instruction_core_top_tb.sv
